>>> sv/scdtm_pkg.sv
package scdtm_pkg;

  // Configuration register widths
  localparam int DRIVE_W = 24;
  localparam int NORM_W  = 23;
  localparam int TONE_W  = 17;
  localparam int MIX_W   = 17;
  localparam int OGAIN_W = 18;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE = 3'd0,
    REG_NORM  = 3'd1,
    REG_TONE  = 3'd2,
    REG_MIX   = 3'd3,
    REG_OGAIN = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [DRIVE_W-1:0] DRIVE_RST = 24'd260904;
  localparam logic [NORM_W-1:0]  NORM_RST  = 23'd4197240;
  localparam logic [TONE_W-1:0]  TONE_RST  = 17'd41354;
  localparam logic [MIX_W-1:0]   MIX_RST   = 17'd65536;
  localparam logic [OGAIN_W-1:0] OGAIN_RST = 18'd65536;

  // 1.0 in Q1.16
  localparam logic [16:0] UNIT_Q16 = 17'd65536;

  // 1.0 in Q31, used when building the tanh table
  localparam longint ONE_Q31 = longint'(1) <<< 31;

  // Lowpass state limits
  localparam longint INT32_MAX = 64'sd2147483647;
  localparam longint INT32_MIN = -64'sd2147483648;

  // Shared multiplier: signed A x signed B, registered product
  localparam int MUL_A_W = 38;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = 63;

  // |sample * drive| in Q.28
  localparam int XQ_W = 37;

  typedef logic signed [MUL_P_W-1:0] prod_t;

  // Operand pair routed to the shared multiplier
  typedef enum logic [2:0] {
    MSEL_DRIVE  = 3'd0,
    MSEL_POS    = 3'd1,
    MSEL_INTERP = 3'd2,
    MSEL_NORM   = 3'd3,
    MSEL_TONE   = 3'd4,
    MSEL_DRY    = 3'd5,
    MSEL_WET    = 3'd6,
    MSEL_OGAIN  = 3'd7
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     in_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     idx_load;
    logic     rd_next;
    logic     y_load;
    logic     clip_load;
    logic     step_load;
    logic     st_update;
    logic     acc_load;
    logic     sum_load;
    logic     blend_load;
    logic     out_load;
  } dp_cmd_t;

  // Shift right with rounding to nearest, halves away from zero
  function automatic prod_t round_shift(prod_t v, int unsigned sh);
    prod_t mag;
    prod_t half;
    if (sh == 0) begin
      return v;
    end
    mag  = v[MUL_P_W-1] ? -v : v;
    half = prod_t'(1) << (sh - 1);
    mag  = (mag + half) >> sh;
    return v[MUL_P_W-1] ? -mag : mag;
  endfunction

endpackage

>>> sv/scdtm_if.sv
// Sample request channel
interface scdtm_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          channel;

  modport source (output valid, in_sample, channel, input ready);
  modport sink   (input valid, in_sample, channel, output ready);
endinterface

// Result channel
interface scdtm_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink   (input valid, out_sample, output ready);
endinterface

// Register write channel
interface scdtm_cfg_if;
  import scdtm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/scdtm_mul.sv
module scdtm_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [scdtm_pkg::MUL_A_W-1:0] a,
  input  logic signed [scdtm_pkg::MUL_B_W-1:0] b,
  output scdtm_pkg::prod_t                    p_r
);
  import scdtm_pkg::*;

  // One signed product per cycle, held until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

>>> sv/scdtm_ctrl.sv
module scdtm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output scdtm_pkg::dp_cmd_t cmd
);
  import scdtm_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_DRV  = 18'h00002,
    ST_POS  = 18'h00004,
    ST_IDX  = 18'h00008,
    ST_RD1  = 18'h00010,
    ST_INT  = 18'h00020,
    ST_Y    = 18'h00040,
    ST_NRM  = 18'h00080,
    ST_CLIP = 18'h00100,
    ST_LP   = 18'h00200,
    ST_LPS  = 18'h00400,
    ST_ST   = 18'h00800,
    ST_BL1  = 18'h01000,
    ST_BL2  = 18'h02000,
    ST_BLS  = 18'h04000,
    ST_BLR  = 18'h08000,
    ST_OG   = 18'h10000,
    ST_OUT  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequencer: one step of the sample computation per state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
        if (in_valid) begin
          state_nxt = ST_DRV;
        end
      end
      ST_DRV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DRIVE;
        state_nxt   = ST_POS;
      end
      ST_POS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_POS;
        state_nxt   = ST_IDX;
      end
      ST_IDX: begin
        cmd.idx_load = 1'b1;
        state_nxt    = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_next = 1'b1;
        state_nxt   = ST_INT;
      end
      ST_INT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_INTERP;
        state_nxt   = ST_Y;
      end
      ST_Y: begin
        cmd.y_load = 1'b1;
        state_nxt  = ST_NRM;
      end
      ST_NRM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_NORM;
        state_nxt   = ST_CLIP;
      end
      ST_CLIP: begin
        cmd.clip_load = 1'b1;
        state_nxt     = ST_LP;
      end
      ST_LP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_TONE;
        state_nxt   = ST_LPS;
      end
      ST_LPS: begin
        cmd.step_load = 1'b1;
        state_nxt     = ST_ST;
      end
      ST_ST: begin
        cmd.st_update = 1'b1;
        state_nxt     = ST_BL1;
      end
      ST_BL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DRY;
        state_nxt   = ST_BL2;
      end
      ST_BL2: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MSEL_WET;
        state_nxt    = ST_BLS;
      end
      ST_BLS: begin
        cmd.sum_load = 1'b1;
        state_nxt    = ST_BLR;
      end
      ST_BLR: begin
        cmd.blend_load = 1'b1;
        state_nxt      = ST_OG;
      end
      ST_OG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_OGAIN;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/scdtm_dp.sv
module scdtm_dp #(
  parameter int SAMPLE_BITS      = 24,
  parameter int CHANNELS         = 2,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  scdtm_pkg::dp_cmd_t                 cmd,
  input  logic                               cfg_we,
  input  logic [scdtm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scdtm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               in_channel,
  output logic signed [SAMPLE_BITS-1:0]      out_sample
);
  import scdtm_pkg::*;

  localparam int TAB_N    = TANH_TABLE_DEPTH + 1;
  localparam int IDX_W    = $clog2(TAB_N);
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XQ_SH    = SAMPLE_BITS - 13;
  localparam int Y_SH     = 32 - SAMPLE_BITS;
  localparam int Y_W      = SAMPLE_BITS + 1;
  localparam int CLIP_W   = SAMPLE_BITS + 2;
  localparam int STEP_W   = 37;
  localparam int BLEND_W  = 33;
  localparam prod_t SMAX  = prod_t'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam prod_t SMIN  = -SMAX - prod_t'(1);

  typedef logic [TAB_N-1:0][31:0] tab_t;

  // Quotient of two non-negative values, shift and subtract
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int p = 62; p >= 0; p--) begin
      rem = (rem <<< 1) | ((num >>> p) & longint'(1));
      q   = q <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | longint'(1);
      end
    end
    return q;
  endfunction

  // e^(-f) in Q31 for f in [0,1], truncated Taylor series
  function automatic longint exp_neg_q31(longint f);
    longint term;
    longint sum;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (int i = 1; i <= 16; i++) begin
      term = udiv((term * f) >>> 31, longint'(i));
      sum  = i[0] ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // tanh over [0,8] in Q0.31, tanh = (1-t)/(1+t) with t = e^(-2x)
  function automatic tab_t build_tab();
    tab_t   tab;
    longint e1;
    longint t;
    longint z;
    longint n;
    longint r;
    e1 = exp_neg_q31(ONE_Q31);
    for (int k = 0; k < TAB_N; k++) begin
      z = longint'(16) * k;
      n = udiv(z, longint'(TANH_TABLE_DEPTH));
      r = z - n * longint'(TANH_TABLE_DEPTH);
      t = exp_neg_q31(udiv(r <<< 31, longint'(TANH_TABLE_DEPTH)));
      for (longint j = 0; j < n; j++) begin
        t = (t * e1) >>> 31;
      end
      tab[k] = 32'(udiv((ONE_Q31 - t) <<< 31, ONE_Q31 + t));
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tab();

  // Configuration registers
  logic [DRIVE_W-1:0] drive_r;
  logic [NORM_W-1:0]  norm_r;
  logic [TONE_W-1:0]  tone_r;
  logic [MIX_W-1:0]   mix_r;
  logic [OGAIN_W-1:0] ogain_r;

  // Per-sample working registers
  logic signed [SAMPLE_BITS-1:0] dry_r;
  logic [CH_W-1:0]               ch_r;
  logic [IDX_W-1:0]              idx_r;
  logic [15:0]                   frac_r;
  logic                          sat_r;
  logic [31:0]                   rom_q_r;
  logic [31:0]                   lo_r;
  logic signed [Y_W-1:0]         y_r;
  logic signed [CLIP_W-1:0]      clip_r;
  logic signed [STEP_W-1:0]      step_r;
  logic signed [31:0]            st_new_r;
  prod_t                         acc_r;
  prod_t                         sum_r;
  logic signed [BLEND_W-1:0]     blend_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic signed [31:0]            lp_state_r [CHANNELS];

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  prod_t                     prod_r;

  scdtm_mul u_mul (
    .clk (clk),
    .en  (cmd.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // Derived values
  logic [SAMPLE_BITS-1:0]     mag;
  logic [XQ_W-1:0]            xq;
  logic [MUL_P_W-33:0]        idx_wide;
  logic                       sat;
  logic [IDX_W-1:0]           rom_addr;
  logic                       rom_en;
  logic [32:0]                y31;
  prod_t                      y_rnd;
  prod_t                      clip_rnd;
  prod_t                      step_rnd;
  prod_t                      blend_rnd;
  prod_t                      o_rnd;
  logic signed [31:0]         st_cur;
  logic signed [STEP_W:0]     st_sum;
  logic signed [31:0]         st_next;
  logic [TONE_W-1:0]          a_eff;
  logic [MIX_W-1:0]           w_eff;
  logic [CH_W-1:0]            ch_in;

  assign mag      = dry_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-dry_r) : SAMPLE_BITS'(dry_r);
  assign xq       = prod_r[XQ_SH +: XQ_W];
  assign idx_wide = prod_r[MUL_P_W-2:31];
  assign sat      = idx_wide >= (MUL_P_W-32)'(TANH_TABLE_DEPTH);
  assign a_eff    = (tone_r > UNIT_Q16) ? UNIT_Q16 : tone_r;
  assign w_eff    = (mix_r > UNIT_Q16) ? UNIT_Q16 : mix_r;
  assign st_cur   = lp_state_r[ch_r];
  assign ch_in    = ((CH_W + 1)'(in_channel) >= (CH_W + 1)'(CHANNELS)) ?
                    CH_W'(CHANNELS - 1) : CH_W'(in_channel);

  // Interpolation and rounding steps
  assign y31       = {1'b0, lo_r} + {1'b0, prod_r[47:16]};
  assign y_rnd     = round_shift(prod_t'(y31), Y_SH);
  assign clip_rnd  = round_shift(prod_r, 22);
  assign step_rnd  = round_shift(prod_r, 16);
  assign blend_rnd = round_shift(sum_r, 16);
  assign o_rnd     = round_shift(prod_r, 16);

  // Lowpass update with saturation to 32 bits
  assign st_sum = (STEP_W + 1)'(st_cur) + (STEP_W + 1)'(step_r);
  always_comb begin
    priority if (st_sum > (STEP_W + 1)'(INT32_MAX)) begin
      st_next = 32'(INT32_MAX);
    end else if (st_sum < (STEP_W + 1)'(INT32_MIN)) begin
      st_next = 32'(INT32_MIN);
    end else begin
      st_next = 32'(st_sum);
    end
  end

  // Multiplier operand routing
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_DRIVE: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(drive_r);
      end
      MSEL_POS: begin
        mul_a = MUL_A_W'(xq);
        mul_b = MUL_B_W'(TANH_TABLE_DEPTH);
      end
      MSEL_INTERP: begin
        mul_a = MUL_A_W'({1'b0, rom_q_r} - {1'b0, lo_r});
        mul_b = MUL_B_W'(frac_r);
      end
      MSEL_NORM: begin
        mul_a = MUL_A_W'(y_r);
        mul_b = MUL_B_W'(norm_r);
      end
      MSEL_TONE: begin
        mul_a = MUL_A_W'(clip_r) - MUL_A_W'(st_cur);
        mul_b = MUL_B_W'(a_eff);
      end
      MSEL_DRY: begin
        mul_a = MUL_A_W'(dry_r);
        mul_b = MUL_B_W'(UNIT_Q16 - w_eff);
      end
      MSEL_WET: begin
        mul_a = MUL_A_W'(st_new_r);
        mul_b = MUL_B_W'(w_eff);
      end
      MSEL_OGAIN: begin
        mul_a = MUL_A_W'(blend_r);
        mul_b = MUL_B_W'(ogain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Table address: lower point first, upper point on the next read
  always_comb begin
    if (cmd.rd_next) begin
      rom_addr = sat_r ? idx_r : IDX_W'(idx_r + 1'b1);
    end else begin
      rom_addr = sat ? IDX_W'(TANH_TABLE_DEPTH) : idx_wide[IDX_W-1:0];
    end
  end
  assign rom_en = cmd.idx_load | cmd.rd_next;

  // tanh table
  always_ff @(posedge clk) begin
    if (rom_en) begin
      rom_q_r <= TANH_TAB[rom_addr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= DRIVE_RST;
      norm_r  <= NORM_RST;
      tone_r  <= TONE_RST;
      mix_r   <= MIX_RST;
      ogain_r <= OGAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRIVE: drive_r <= cfg_data[DRIVE_W-1:0];
        REG_NORM:  norm_r  <= cfg_data[NORM_W-1:0];
        REG_TONE:  tone_r  <= cfg_data[TONE_W-1:0];
        REG_MIX:   mix_r   <= cfg_data[MIX_W-1:0];
        REG_OGAIN: ogain_r <= cfg_data[OGAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lowpass memory per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lp_state_r[c] <= '0;
      end
    end else if (cmd.st_update) begin
      lp_state_r[ch_r] <= st_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      dry_r <= in_sample;
      ch_r  <= ch_in;
    end
    if (cmd.idx_load) begin
      idx_r  <= sat ? IDX_W'(TANH_TABLE_DEPTH) : idx_wide[IDX_W-1:0];
      frac_r <= sat ? 16'd0 : prod_r[30:15];
      sat_r  <= sat;
    end
    if (cmd.rd_next) begin
      lo_r <= rom_q_r;
    end
    if (cmd.y_load) begin
      y_r <= Y_W'(y_rnd);
    end
    if (cmd.clip_load) begin
      clip_r <= dry_r[SAMPLE_BITS-1] ? CLIP_W'(-clip_rnd) : CLIP_W'(clip_rnd);
    end
    if (cmd.step_load) begin
      step_r <= STEP_W'(step_rnd);
    end
    if (cmd.st_update) begin
      st_new_r <= st_next;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.sum_load) begin
      sum_r <= acc_r + prod_r;
    end
    if (cmd.blend_load) begin
      blend_r <= BLEND_W'(blend_rnd);
    end
    if (cmd.out_load) begin
      priority if (o_rnd > SMAX) begin
        out_r <= SAMPLE_BITS'(SMAX);
      end else if (o_rnd < SMIN) begin
        out_r <= SAMPLE_BITS'(SMIN);
      end else begin
        out_r <= SAMPLE_BITS'(o_rnd);
      end
    end
  end

  assign out_sample = out_r;

endmodule

>>> sv/soft_clip_distortion_tone_mix_unit.sv
// Stereo tanh soft-clip distortion with a one-pole tone lowpass and a dry/wet
// blend. Each sample request is scaled by the drive gain, shaped by tanh from
// an interpolated table of TANH_TABLE_DEPTH+1 points (built at elaboration),
// scaled by the normaliser, filtered per channel by y += a*(x-y), blended
// with the dry sample, scaled by the output gain and saturated to
// SAMPLE_BITS. One request is processed at a time: a new request is accepted
// only after the previous one has passed all steps, which are the eight
// products that share a single registered multiplier, two table reads and
// the rounding steps between them. The result sits in an output register, so
// the next request is accepted while it waits to be taken.
// Register writes are always accepted (cfg ready is tied high) and should be
// issued only while no request is in flight.
module soft_clip_distortion_tone_mix_unit #(
  parameter int SAMPLE_BITS      = 24,
  parameter int CHANNELS         = 2,
  parameter int TANH_TABLE_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  scdtm_in_if.sink     in_chan,
  scdtm_out_if.source  out_chan,
  scdtm_cfg_if.sink    cfg_chan
);
  import scdtm_pkg::*;

  dp_cmd_t cmd;

  scdtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  scdtm_dp #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CHANNELS         (CHANNELS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .in_sample  (in_chan.in_sample),
    .in_channel (in_chan.channel),
    .out_sample (out_chan.out_sample)
  );

  // Register writes never stall
  assign cfg_chan.ready = 1'b1;

endmodule

>>> test/tb_soft_clip_distortion_tone_mix_unit.sv
`timescale 1ns / 100ps

module tb_soft_clip_distortion_tone_mix_unit;
  import scdtm_pkg::*;

  localparam int SAMPLE_BITS  = 24;
  localparam int CHANNELS     = 2;
  localparam int LUT_DEPTH    = 1024;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_HOLD    = 300;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 24'sh800000;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  // Indexes past the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef enum {SET_RANDOM, SET_MIN, SET_MAX} reg_set_t;

  logic clk = 1'b0;
  logic rst_n;

  scdtm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_chan ();
  scdtm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_chan ();
  scdtm_cfg_if                              cfg_chan ();

  soft_clip_distortion_tone_mix_unit #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CHANNELS         (CHANNELS),
    .TANH_TABLE_DEPTH (LUT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #1 clk = ~clk;

  // Predictor state: tanh table, register shadows, per-channel lowpass memory
  logic [31:0]        tanh_lut [0:LUT_DEPTH];
  logic [DRIVE_W-1:0] drive_r;
  logic [NORM_W-1:0]  norm_r;
  logic [TONE_W-1:0]  tone_r;
  logic [MIX_W-1:0]   mix_r;
  logic [OGAIN_W-1:0] ogain_r;
  longint             lp_mem [CHANNELS];

  logic signed [SAMPLE_BITS-1:0] distorted_q [$];

  int src_gap_max = 0;
  int snk_gap_max = 0;
  int snk_hold    = 0;
  int bad_results = 0;
  int result_cnt  = 0;

  // e^(-f), f and result in Q31, truncated Taylor series
  function automatic longint exp_neg_q31(longint f);
    longint term;
    longint sum;
    int     i;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (i = 1; i <= 16; i++) begin
      term = ((term * f) >>> 31) / i;
      sum  = (i % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  // tanh over [0,8] in Q0.31 as (1-t)/(1+t), t = e^(-2x)
  function automatic void build_tanh_lut();
    longint          e1;
    longint          t;
    longint unsigned z;
    longint unsigned n;
    longint unsigned r;
    longint unsigned j;
    int              k;
    e1 = exp_neg_q31(ONE_Q31);
    for (k = 0; k <= LUT_DEPTH; k++) begin
      z = 64'(16 * k);
      n = z / LUT_DEPTH;
      r = z % LUT_DEPTH;
      t = exp_neg_q31(longint'((r << 31) / LUT_DEPTH));
      for (j = 0; j < n; j++)
        t = (t * e1) >>> 31;
      tanh_lut[k] = 32'(((ONE_Q31 - t) <<< 31) / (ONE_Q31 + t));
    end
  endfunction

  // Shift right, round to nearest, halves away from zero
  function automatic longint round_off(longint v, int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void reset_model();
    drive_r   = DRIVE_RST;
    norm_r    = NORM_RST;
    tone_r    = TONE_RST;
    mix_r     = MIX_RST;
    ogain_r   = OGAIN_RST;
    lp_mem[0] = 0;
    lp_mem[1] = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DRIVE: drive_r = d[DRIVE_W-1:0];
      REG_NORM:  norm_r  = d[NORM_W-1:0];
      REG_TONE:  tone_r  = d[TONE_W-1:0];
      REG_MIX:   mix_r   = d[MIX_W-1:0];
      REG_OGAIN: ogain_r = d[OGAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Full sample path; advances the lowpass memory of the channel
  function automatic logic signed [SAMPLE_BITS-1:0] distort_sample(
    logic signed [SAMPLE_BITS-1:0] s, logic ch);
    longint          dry, y, clip, st, a, w, blend, o;
    longint unsigned mag, xq, pos, idx, frac, y31;
    logic [31:0]     slope;
    dry = longint'(s);
    mag = (dry < 0) ? -dry : dry;

    // tanh(|s * drive|) from the interpolated table
    xq  = (mag * drive_r) >> (SAMPLE_BITS - 13);
    pos = xq * LUT_DEPTH;
    idx = pos >> 31;
    if (idx >= LUT_DEPTH) begin
      y31 = tanh_lut[LUT_DEPTH];
    end else begin
      frac  = (pos >> 15) & 64'hFFFF;
      slope = tanh_lut[idx + 1] - tanh_lut[idx];
      y31   = 64'(tanh_lut[idx]) + ((64'(slope) * frac) >> 16);
    end
    y    = round_off(longint'(y31), 32 - SAMPLE_BITS);
    clip = round_off(y * longint'(norm_r), 22);
    if (dry < 0)
      clip = -clip;

    // one-pole lowpass, coefficient capped at 1.0
    a  = (tone_r > UNIT_Q16) ? longint'(UNIT_Q16) : longint'(tone_r);
    st = lp_mem[ch];
    st = st + round_off(a * (clip - st), 16);
    if (st > INT32_MAX)
      st = INT32_MAX;
    else if (st < INT32_MIN)
      st = INT32_MIN;
    lp_mem[ch] = st;

    // dry/wet blend, output gain, saturation
    w     = (mix_r > UNIT_Q16) ? longint'(UNIT_Q16) : longint'(mix_r);
    blend = round_off(dry * (longint'(UNIT_Q16) - w) + st * w, 16);
    o     = round_off(blend * longint'(ogain_r), 16);
    if (o > SAMPLE_MAX)
      o = SAMPLE_MAX;
    else if (o < SAMPLE_MIN)
      o = SAMPLE_MIN;
    return o[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return 24'(int'($urandom_range(0, 255)) - 128);
      3, 4:    return 24'(int'($urandom_range(0, 131071)) - 65536);
      default: return 24'($urandom());
    endcase
  endfunction

  // One request on the sample channel; expectation recorded at acceptance
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic ch);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.in_sample <= s;
    in_chan.channel   <= ch;
    do @(posedge clk); while (!in_chan.ready);
    distorted_q.push_back(distort_sample(s, ch));
  endtask

  // Stop offering requests and wait until every result is back
  task automatic wait_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (distorted_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= d;
    do @(posedge clk); while (!cfg_chan.ready);
    apply_reg(idx, d);
  endtask

  // All five registers, then optional junk to the unused indexes
  task automatic program_regs(logic [CFG_DATA_W-1:0] drv, logic [CFG_DATA_W-1:0] nrm,
                              logic [CFG_DATA_W-1:0] ton, logic [CFG_DATA_W-1:0] mx,
                              logic [CFG_DATA_W-1:0] og, logic spares);
    int k;
    write_reg(REG_DRIVE, drv);
    write_reg(REG_NORM, nrm);
    write_reg(REG_TONE, ton);
    write_reg(REG_MIX, mx);
    write_reg(REG_OGAIN, og);
    if (spares) begin
      for (k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
        write_reg(CFG_IDX_W'(k), 24'($urandom()));
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic program_random();
    logic [CFG_DATA_W-1:0] drv, nrm, ton, mx, og;
    drv = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                                      : 24'($urandom_range(65536, 1048575));
    nrm = 24'($urandom_range(4194304, 8388607));
    ton = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(65537, 131071))
                                      : 24'($urandom_range(0, 65536));
    mx  = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(65537, 131071))
                                      : 24'($urandom_range(0, 65536));
    og  = 24'($urandom_range(0, 262143));
    program_regs(drv, nrm, ton, mx, og, 1'($urandom_range(0, 1)));
  endtask

  // Reset register values, full-scale and near-zero samples on both channels
  task automatic test_reset_values();
    src_gap_max = 0;
    snk_gap_max = 0;
    send_sample(24'sd0, 1'b0);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b1);
    send_sample(24'sd1, 1'b1);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sh400000, 1'b1);
    send_sample(-24'sh400000, 1'b0);
    send_sample(24'sh000100, 1'b1);
  endtask

  // Maximum drive runs off the table end; maximum gain saturates the output
  task automatic test_hot_drive();
    wait_results();
    program_regs(24'hFFFFFF, 24'h7FFFFF, 24'h010000, 24'h010000, 24'h03FFFF, 1'b1);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b1);
    send_sample(24'sd40, 1'b0);
  endtask

  // Over-wide writes: tone and mix above 1.0, registers below their stated range
  task automatic test_overrange_regs();
    wait_results();
    program_regs(24'd1000, 24'd100, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_sample(FULL_POS, 1'b1);
    send_sample(24'sh123456, 1'b0);
    send_sample(FULL_NEG, 1'b1);
  endtask

  // Frozen lowpass, fully dry blend at maximum output gain
  task automatic test_dry_path();
    wait_results();
    program_regs(24'd260904, 24'd4197240, 24'd0, 24'd0, 24'h03FFFF, 1'b0);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b1);
    send_sample(24'sh100000, 1'b0);
  endtask

  task automatic test_random_phase(reg_set_t kind, int count, int src_max, int snk_max);
    wait_results();
    src_gap_max = src_max;
    snk_gap_max = snk_max;
    case (kind)
      SET_MIN: program_regs(24'd65536, 24'd4194304, 24'd0, 24'd0, 24'd0, 1'b0);
      SET_MAX: program_regs(24'hFFFFFF, 24'h7FFFFF, 24'h010000, 24'h010000, 24'h03FFFF, 1'b1);
      default: program_random();
    endcase
    repeat (count) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Sink stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    wait_results();
    program_random();
    src_gap_max = 0;
    snk_gap_max = 0;
    snk_hold    = LONG_HOLD;
    repeat (40) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Sender goes quiet until the block has fully drained, then resumes
  task automatic test_sender_pause();
    wait_results();
    program_random();
    src_gap_max = 10;
    snk_gap_max = 10;
    repeat (30) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
    wait_results();
    repeat (30) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Result sink: random stall per result plus an occasional long hold
  initial begin : result_sink
    int stall;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, snk_gap_max);
      if (snk_hold > 0) begin
        stall    = stall + snk_hold;
        snk_hold = 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_cnt++;
      if (distorted_q.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("result %0d: unexpected out_sample %0d", result_cnt,
                   out_chan.out_sample);
      end else begin
        want = distorted_q.pop_front();
        if (out_chan.out_sample !== want) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("result %0d: out_sample expected %0d got %0d", result_cnt,
                     want, out_chan.out_sample);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb_soft_clip_distortion_tone_mix_unit: FAIL");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.in_sample  <= '0;
    in_chan.channel    <= 1'b0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.index     <= '0;
    cfg_chan.data      <= '0;
    build_tanh_lut();
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_hot_drive();
    test_overrange_regs();
    test_dry_path();
    test_random_phase(SET_RANDOM, 200, 10, 10);
    test_random_phase(SET_RANDOM, 200, 0, 0);
    test_backpressure();
    test_random_phase(SET_MAX, 100, 0, 10);
    test_random_phase(SET_RANDOM, 200, 10, 0);
    test_sender_pause();
    test_random_phase(SET_MIN, 50, 3, 3);
    test_random_phase(SET_RANDOM, 200, 5, 5);

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0 && distorted_q.size() == 0) begin
      $display("tb_soft_clip_distortion_tone_mix_unit: PASS");
    end else begin
      $display("tb_soft_clip_distortion_tone_mix_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/scdtm_pkg.sv
sv/scdtm_if.sv
sv/scdtm_mul.sv
sv/scdtm_ctrl.sv
sv/scdtm_dp.sv
sv/soft_clip_distortion_tone_mix_unit.sv
test/tb_soft_clip_distortion_tone_mix_unit.sv
